>>> rtl/core/multi_channel_sensor_frame_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH
`define MULTI_CHANNEL_SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every clock edge outside reset
`define DFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Checked on every clock edge, reset included
`define DFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
	else $error(msg);

`else

`define DFR_ASSERT(lbl, prop, msg)
`define DFR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/core/dfr_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Word and record types, register indexes and frame constants.
// ----------------------------------------------------------------------------
package dfr_pkg;

	localparam int CHANNELS_DEF  = 4;
	localparam int CHANNEL_W     = 2;
	localparam int BYTE_W        = 8;
	localparam int PAYLOAD_BYTES = 6;
	localparam int LANE_W        = 3;
	localparam int POS_W         = 3;
	localparam int WALL_W        = 6;

	localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FIRST  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_FOOTER = POS_W'(PAYLOAD_BYTES + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FOOTER = CFG_IDX_W'(1);

	localparam logic [BYTE_W-1:0] HEADER_RST = 8'hFF;
	localparam logic [BYTE_W-1:0] FOOTER_RST = 8'hAA;

	// Payload byte positions within a stored row
	localparam int LANE_BALL_DIR  = 0;
	localparam int LANE_BALL_DIST = 1;
	localparam int LANE_GOAL_DIR  = 2;
	localparam int LANE_GOAL_HGT  = 3;
	localparam int LANE_FLAGS     = 4;
	localparam int LANE_PROX      = 5;

	typedef logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] payload_row_t;

	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		logic [BYTE_W-1:0]    rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [CHANNEL_W-1:0] source_channel;
		logic [BYTE_W-1:0]    ball_direction;
		logic [BYTE_W-1:0]    ball_distance;
		logic [BYTE_W-1:0]    goal_direction;
		logic [BYTE_W-1:0]    goal_elevation;
		logic                 goal_is_yellow;
		logic                 goal_in_front;
		logic [WALL_W-1:0]    wall_distance;
		logic [BYTE_W-1:0]    proximity;
	} rec_t;

	// Frame controller to payload store and record stage
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [LANE_W-1:0] lane;
		logic [BYTE_W-1:0] wdata;
	} mem_cmd_t;

	// Record stage status back to the top level
	typedef struct packed {
		logic s1_valid;
		logic free;
	} stage_stat_t;

endpackage

>>> rtl/core/dfr_frame_ctl.sv
// ----------------------------------------------------------------------------
// Deframer frame controller
// Header and footer registers, per-channel frame position and word decode.
// ----------------------------------------------------------------------------
module dfr_frame_ctl #(
	parameter int CHANNELS = dfr_pkg::CHANNELS_DEF,
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  dfr_pkg::in_word_t              word,
	input  logic                           cfg_wr_en,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dfr_pkg::BYTE_W-1:0]     cfg_wdata,
	output dfr_pkg::mem_cmd_t              cmd,
	output logic [CH_W-1:0]                row
);
	import dfr_pkg::*;

	localparam int CHX_W = (CH_W > CHANNEL_W) ? CH_W : CHANNEL_W;

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] footer_q;
	logic [POS_W-1:0]  pos_q [CHANNELS];

	logic [CHX_W-1:0]  chx;
	logic              in_range;
	logic [POS_W-1:0]  pos;
	logic [POS_W-1:0]  pos_nxt;
	logic              upd;

	assign chx      = CHX_W'(word.channel);
	assign row      = chx[CH_W-1:0];
	assign in_range = (32'(chx) < 32'(CHANNELS));
	assign pos      = pos_q[row];

	always_comb begin
		cmd       = '0;
		cmd.wdata = word.rx_byte;
		cmd.lane  = LANE_W'(pos - POS_FIRST);
		pos_nxt   = pos;
		upd       = accept && in_range;
		if (pos == POS_HUNT) begin
			if (word.rx_byte == header_q) begin
				pos_nxt = POS_FIRST;
			end
		end else if (pos >= POS_FOOTER) begin
			// back to hunting whether or not the footer matches
			pos_nxt = POS_HUNT;
			cmd.rd  = upd && (word.rx_byte == footer_q);
		end else begin
			pos_nxt = pos + POS_FIRST;
			cmd.wr  = upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= POS_HUNT;
			end
		end else if (upd) begin
			pos_q[row] <= pos_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
			footer_q <= FOOTER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_HEADER: header_q <= cfg_wdata;
				REG_FOOTER: footer_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/dfr_payload_mem.sv
// ----------------------------------------------------------------------------
// Deframer payload store
// One row of payload bytes per channel, byte write, registered row read.
// ----------------------------------------------------------------------------
module dfr_payload_mem #(
	parameter int CHANNELS = dfr_pkg::CHANNELS_DEF,
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                  clk,
	input  dfr_pkg::mem_cmd_t     cmd,
	input  logic [CH_W-1:0]       row,
	output dfr_pkg::payload_row_t rd_row_s1
);
	import dfr_pkg::*;

	payload_row_t mem [CHANNELS];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[row][cmd.lane] <= cmd.wdata;
		end
	end

	// the footer word reads the whole row at once
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_row_s1 <= mem[row];
		end
	end

endmodule

>>> rtl/core/dfr_out_stage.sv
// ----------------------------------------------------------------------------
// Deframer record stage
// Holds a completed frame, unpacks it and registers the outgoing record.
// ----------------------------------------------------------------------------
module dfr_out_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           hit,
	input  logic [dfr_pkg::CHANNEL_W-1:0]  channel,
	input  dfr_pkg::payload_row_t          rd_row_s1,
	input  logic                           rec_ready,
	output logic                           rec_valid,
	output dfr_pkg::rec_t                  rec_data,
	output dfr_pkg::stage_stat_t           stat
);
	import dfr_pkg::*;

	logic                 valid_s1;
	logic [CHANNEL_W-1:0] channel_s1;
	logic                 out_valid_q;
	rec_t                 rec_q;
	rec_t                 rec_nxt;
	logic                 adv;
	logic [BYTE_W-1:0]    flags;

	assign adv = valid_s1 && (!out_valid_q || rec_ready);

	assign stat.s1_valid = valid_s1;
	assign stat.free     = !valid_s1 || adv;

	assign flags = rd_row_s1[LANE_FLAGS];

	always_comb begin
		rec_nxt.source_channel = channel_s1;
		rec_nxt.ball_direction = rd_row_s1[LANE_BALL_DIR];
		rec_nxt.ball_distance  = rd_row_s1[LANE_BALL_DIST];
		rec_nxt.goal_direction = rd_row_s1[LANE_GOAL_DIR];
		rec_nxt.goal_elevation = rd_row_s1[LANE_GOAL_HGT];
		rec_nxt.goal_is_yellow = flags[0];
		rec_nxt.goal_in_front  = flags[1];
		rec_nxt.wall_distance  = flags[BYTE_W-1:2];
		rec_nxt.proximity      = rd_row_s1[LANE_PROX];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= hit;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rec_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			channel_s1 <= channel;
		end
		if (adv) begin
			rec_q <= rec_nxt;
		end
	end

	assign rec_valid = out_valid_q;
	assign rec_data  = rec_q;

endmodule

>>> rtl/core/multi_channel_sensor_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Multi-channel sensor frame deframer
// Per-channel header / payload / footer framing of tagged serial bytes.
// ----------------------------------------------------------------------------
// Input words (byte_valid/byte_ready/byte_data) carry a channel tag and one
// received byte. Each channel hunts for the header byte, stores six payload
// bytes and then checks the footer byte; a matching footer yields one decoded
// record on rec_valid/rec_ready/rec_data, a wrong one yields nothing. Either
// way the channel returns to hunting. Words tagged beyond CHANNELS are dropped.
// Header and footer values are set through cfg_wr_en/cfg_index/cfg_wdata
// (index 0 header, index 1 footer); the user writes them only while the block
// is idle, which the block itself does not enforce. Throughput: one word per
// cycle while byte_ready is high. A record reaches rec_valid through the
// payload row read into the holding stage and then the output register.
// When the receiver stalls, the held record and the output register absorb
// two completed frames; byte_ready falls only while both are full and the
// receiver is not taking the output.
// Reset returns every channel to hunting, restores the header to 0xFF and
// the footer to 0xAA and empties both stages. The payload store is not
// cleared: an entry is always written before a completed frame reads it.
// ----------------------------------------------------------------------------
`include "multi_channel_sensor_frame_deframer_core_macros.svh"

module multi_channel_sensor_frame_deframer_core #(
	parameter int CHANNELS = dfr_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  dfr_pkg::in_word_t             byte_data,
	output logic                          rec_valid,
	input  logic                          rec_ready,
	output dfr_pkg::rec_t                 rec_data,
	input  logic                          cfg_wr_en,
	input  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dfr_pkg::BYTE_W-1:0]    cfg_wdata
);
	import dfr_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic          accept;
	mem_cmd_t      cmd;
	logic [CH_W-1:0] row;
	payload_row_t  rd_row_s1;
	stage_stat_t   stat;

	assign byte_ready = stat.free;
	assign accept     = byte_valid && byte_ready;

	dfr_frame_ctl #(
		.CHANNELS (CHANNELS)
	) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.word      (byte_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.row       (row)
	);

	dfr_payload_mem #(
		.CHANNELS (CHANNELS)
	) u_mem (
		.clk       (clk),
		.cmd       (cmd),
		.row       (row),
		.rd_row_s1 (rd_row_s1)
	);

	dfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.hit       (cmd.rd),
		.channel   (byte_data.channel),
		.rd_row_s1 (rd_row_s1),
		.rec_ready (rec_ready),
		.rec_valid (rec_valid),
		.rec_data  (rec_data),
		.stat      (stat)
	);

	// a full holding stage behind a stalled output must stop input
	`DFR_ASSERT(a_full_blocks, stat.s1_valid && rec_valid && !rec_ready |-> !byte_ready, "input taken while both stages are full")
	// a record only appears after a frame was held
	`DFR_ASSERT(a_out_from_s1, $rose(rec_valid) |-> $past(stat.s1_valid), "record without a held frame")
	// a held frame only comes from an accepted footer word
	`DFR_ASSERT(a_s1_from_accept, $rose(stat.s1_valid) |-> $past(accept && cmd.rd), "held frame without a footer word")
	// no payload write and row read from the same word
	`DFR_ASSERT_ALWAYS(a_wr_rd_excl, !(cmd.wr && cmd.rd), "payload write and read together")

endmodule
